FILE: rtl/dun_hs_pkg.sv
// Shared types, codes and the handshake pattern for the string handshake core.
`default_nettype none
package dun_hs_pkg;

  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned LEN_W     = 4;

  localparam logic [LEN_W-1:0] SHORT_LEN = 4'd6;
  localparam logic [LEN_W-1:0] LONG_LEN  = 4'd12;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLOSE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FAIL    = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic {
    CFG_IS_SERVER = 1'b0,
    CFG_TIMEOUT   = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WAIT = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  // Words to send, whether a finished word follows them, and its status and ppp flag.
  typedef struct packed {
    logic [LEN_W-1:0] send_len;
    logic             fin;
    logic [1:0]       status;
    logic             ppp;
  } burst_t;

  function automatic logic [7:0] pat_char(input logic [LEN_W-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h43;
      4'd1:    ch = 8'h4C;
      4'd2:    ch = 8'h49;
      4'd3:    ch = 8'h45;
      4'd4:    ch = 8'h4E;
      4'd5:    ch = 8'h54;
      4'd6:    ch = 8'h53;
      4'd7:    ch = 8'h45;
      4'd8:    ch = 8'h52;
      4'd9:    ch = 8'h56;
      4'd10:   ch = 8'h45;
      4'd11:   ch = 8'h52;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/dun_hs_if.sv
// Channel interfaces for commands, result words and register writes.
`default_nettype none
interface dun_hs_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;
  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface dun_hs_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic [1:0] status;
  logic       ppp_seen;
  logic       last;
  modport source (output valid, output kind, output tx_byte, output status,
                  output ppp_seen, output last, input ready);
  modport sink   (input valid, input kind, input tx_byte, input status,
                  input ppp_seen, input last, output ready);
endinterface

interface dun_hs_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/dun_string_handshake_core.sv
// Top level of the string handshake core over a byte link.
//
//   channel  dir  words                      handshake
//   cfg      in   index, data (16 bit)       valid/ready, always ready
//   cmd      in   opcode, rx_byte            valid/ready
//   res      out  kind, tx_byte, status,     valid/ready
//                 ppp_seen, last
//
// A taken command waits in a command register until the sequencer can take its
// words; it yields 0 to 13 words. Words leave at one per cycle while res is ready.
// The sequencer holding the word burst sets the rate; the next command waits
// only when it produces words while the previous burst is still draining.
// Reset (rst, synchronous) returns the core to idle with no words pending.
`default_nettype none
module dun_string_handshake_core #(
  parameter int unsigned WINDOW_BYTES = 39,
  parameter int unsigned ATTEMPTS     = 4
) (
  input wire logic   clk,
  input wire logic   rst,
  dun_hs_cfg_if.sink cfg,
  dun_hs_cmd_if.sink cmd,
  dun_hs_res_if.source res
);

  dun_hs_pkg::burst_t burst;
  logic               burst_valid;
  logic               emit_free;

  dun_hs_engine #(
    .WINDOW_BYTES(WINDOW_BYTES),
    .ATTEMPTS    (ATTEMPTS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .emit_free  (emit_free),
    .burst      (burst),
    .burst_valid(burst_valid)
  );

  dun_hs_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .burst      (burst),
    .burst_valid(burst_valid),
    .emit_free  (emit_free),
    .res        (res)
  );

endmodule
`default_nettype wire

FILE: rtl/dun_hs_engine.sv
// Command register, configuration and handshake state update.
`default_nettype none
module dun_hs_engine #(
  parameter int unsigned WINDOW_BYTES = 39,
  parameter int unsigned ATTEMPTS     = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  dun_hs_cfg_if.sink         cfg,
  dun_hs_cmd_if.sink         cmd,
  input  wire logic          emit_free,
  output dun_hs_pkg::burst_t burst,
  output logic               burst_valid
);

  localparam int unsigned FILL_W    = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned ATT_W     = $clog2(ATTEMPTS + 1);
  localparam int unsigned TW        = dun_hs_pkg::TIMEOUT_W;
  localparam int unsigned DIV_SHIFT = TW + $clog2(ATTEMPTS);
  localparam int unsigned MULT_W    = DIV_SHIFT + 1;
  localparam longint unsigned DIV_MULT =
    ((64'd1 << DIV_SHIFT) + ATTEMPTS - 1) / ATTEMPTS;

  logic          is_server;
  logic [TW-1:0] timeout_ticks;
  logic [TW-1:0] client_limit;
  logic [TW+MULT_W-1:0] quot_prod;

  logic        cmd_vq;
  logic [1:0]  op_q;
  logic [7:0]  byte_q;
  logic        advance;
  logic        burst_empty;

  dun_hs_pkg::phase_t phase, phase_next;
  logic [ATT_W-1:0]  attempts_left, attempts_left_next;
  logic [TW-1:0]     tick_count, tick_count_next;
  logic [FILL_W-1:0] fill_count, fill_count_next;
  logic [dun_hs_pkg::LEN_W-1:0] match_progress, match_progress_next;
  logic tilde_seen, tilde_seen_next;
  logic nul_seen, nul_seen_next;

  logic [dun_hs_pkg::LEN_W-1:0] patlen;
  logic [FILL_W-1:0]            fill_inc;
  logic [TW-1:0]                tick_inc;
  logic [TW-1:0]                limit;
  dun_hs_pkg::burst_t           burst_d;

  // The client per-attempt limit is a reciprocal multiply taken at the write.
  assign quot_prod = (TW+MULT_W)'(cfg.data) * (TW+MULT_W)'(DIV_MULT);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_server     <= 1'b0;
      timeout_ticks <= '0;
      client_limit  <= '0;
    end else if (cfg.valid) begin
      unique case (dun_hs_pkg::cfg_index_t'(cfg.index))
        dun_hs_pkg::CFG_IS_SERVER: is_server <= cfg.data[0];
        dun_hs_pkg::CFG_TIMEOUT: begin
          timeout_ticks <= cfg.data;
          client_limit  <= quot_prod[DIV_SHIFT +: TW];
        end
        default: ;
      endcase
    end
  end

  assign advance     = cmd_vq && (burst_empty || emit_free);
  assign cmd.ready   = !cmd_vq || advance;
  assign burst       = burst_d;
  assign burst_valid = advance && !burst_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vq <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      cmd_vq <= 1'b1;
    end else if (advance) begin
      cmd_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op_q   <= cmd.opcode;
      byte_q <= cmd.rx_byte;
    end
  end

  assign patlen   = is_server ? dun_hs_pkg::SHORT_LEN : dun_hs_pkg::LONG_LEN;
  assign fill_inc = (fill_count < FILL_W'(WINDOW_BYTES)) ? fill_count + 1'b1 : fill_count;
  assign tick_inc = (tick_count != {TW{1'b1}}) ? tick_count + 1'b1 : tick_count;
  assign limit    = is_server ? timeout_ticks : client_limit;
  assign burst_empty = (burst_d.send_len == '0) && !burst_d.fin;

  always_comb begin
    phase_next          = phase;
    attempts_left_next  = attempts_left;
    tick_count_next     = tick_count;
    fill_count_next     = fill_count;
    match_progress_next = match_progress;
    tilde_seen_next     = tilde_seen;
    nul_seen_next       = nul_seen;
    burst_d             = '0;
    unique case (dun_hs_pkg::opcode_t'(op_q))
      dun_hs_pkg::OP_START: begin
        tick_count_next     = '0;
        fill_count_next     = '0;
        match_progress_next = '0;
        tilde_seen_next     = 1'b0;
        nul_seen_next       = 1'b0;
        attempts_left_next  = ATT_W'(ATTEMPTS);
        phase_next          = dun_hs_pkg::PH_WAIT;
        if (!is_server) begin
          burst_d.send_len = dun_hs_pkg::SHORT_LEN;
        end
      end
      dun_hs_pkg::OP_BYTE: begin
        if (phase == dun_hs_pkg::PH_WAIT) begin
          fill_count_next = fill_inc;
          if (!nul_seen) begin
            if (byte_q == dun_hs_pkg::CHAR_NUL) begin
              nul_seen_next = 1'b1;
            end else begin
              if (byte_q == dun_hs_pkg::CHAR_TILDE) begin
                tilde_seen_next = 1'b1;
              end
              if (match_progress < patlen) begin
                if (byte_q == dun_hs_pkg::pat_char(match_progress)) begin
                  match_progress_next = match_progress + 1'b1;
                end else begin
                  match_progress_next = (byte_q == dun_hs_pkg::CHAR_C) ? 4'd1 : 4'd0;
                end
              end
            end
          end
          if (fill_inc >= FILL_W'(patlen) && match_progress_next >= patlen) begin
            phase_next     = dun_hs_pkg::PH_DONE;
            burst_d.fin    = 1'b1;
            burst_d.status = dun_hs_pkg::ST_OK;
            if (is_server) begin
              burst_d.send_len = dun_hs_pkg::LONG_LEN;
            end
          end else if (fill_inc >= FILL_W'(patlen) && tilde_seen_next) begin
            phase_next     = dun_hs_pkg::PH_DONE;
            burst_d.fin    = 1'b1;
            burst_d.status = dun_hs_pkg::ST_OK;
            burst_d.ppp    = 1'b1;
          end else if (fill_inc >= FILL_W'(WINDOW_BYTES)) begin
            phase_next     = dun_hs_pkg::PH_DONE;
            burst_d.fin    = 1'b1;
            burst_d.status = dun_hs_pkg::ST_FAIL;
          end
        end
      end
      dun_hs_pkg::OP_TICK: begin
        if (phase == dun_hs_pkg::PH_WAIT && limit != '0) begin
          tick_count_next = tick_inc;
          if (tick_inc >= limit) begin
            if (!is_server && attempts_left > ATT_W'(1)) begin
              attempts_left_next  = attempts_left - 1'b1;
              tick_count_next     = '0;
              fill_count_next     = '0;
              match_progress_next = '0;
              tilde_seen_next     = 1'b0;
              nul_seen_next       = 1'b0;
              burst_d.send_len    = dun_hs_pkg::SHORT_LEN;
            end else begin
              attempts_left_next = '0;
              phase_next         = dun_hs_pkg::PH_DONE;
              burst_d.fin        = 1'b1;
              burst_d.status     = dun_hs_pkg::ST_TIMEOUT;
            end
          end
        end
      end
      dun_hs_pkg::OP_CLOSE: begin
        if (phase == dun_hs_pkg::PH_WAIT) begin
          phase_next     = dun_hs_pkg::PH_DONE;
          burst_d.fin    = 1'b1;
          burst_d.status = dun_hs_pkg::ST_FAIL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= dun_hs_pkg::PH_IDLE;
      attempts_left  <= '0;
      tick_count     <= '0;
      fill_count     <= '0;
      match_progress <= '0;
      tilde_seen     <= 1'b0;
      nul_seen       <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      attempts_left  <= attempts_left_next;
      tick_count     <= tick_count_next;
      fill_count     <= fill_count_next;
      match_progress <= match_progress_next;
      tilde_seen     <= tilde_seen_next;
      nul_seen       <= nul_seen_next;
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(WINDOW_BYTES))
    else $error("window fill count exceeds the window size");

  a_idle_no_attempts: assert property (@(posedge clk) disable iff (rst)
    phase == dun_hs_pkg::PH_IDLE |-> attempts_left == '0)
    else $error("attempts pending while idle");

  a_hold_unless_advance: assert property (@(posedge clk) disable iff (rst)
    cmd_vq && !advance |=> cmd_vq && $stable(op_q) && $stable(byte_q))
    else $error("held command lost before it was processed");

endmodule
`default_nettype wire

FILE: rtl/dun_hs_emitter.sv
// Result sequencer that plays out one burst of words per processed command that yields words.
`default_nettype none
module dun_hs_emitter (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dun_hs_pkg::burst_t burst,
  input  wire logic          burst_valid,
  output logic               emit_free,
  dun_hs_res_if.source       res
);

  localparam int unsigned LW = dun_hs_pkg::LEN_W;

  logic               busy;
  logic [LW-1:0]      idx;
  dun_hs_pkg::burst_t cur;
  logic [LW-1:0]      total;
  logic               last_item;
  logic               is_fin;

  assign total     = cur.send_len + LW'(cur.fin);
  assign last_item = (idx == total - 1'b1);
  assign is_fin    = (idx >= cur.send_len);
  assign emit_free = !busy || (res.ready && last_item);

  assign res.valid    = busy;
  assign res.kind     = is_fin;
  assign res.tx_byte  = is_fin ? 8'h00 : dun_hs_pkg::pat_char(idx);
  assign res.status   = is_fin ? cur.status : dun_hs_pkg::ST_OK;
  assign res.ppp_seen = is_fin ? cur.ppp : 1'b0;
  assign res.last     = last_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (burst_valid) begin
      busy <= 1'b1;
    end else if (res.valid && res.ready && last_item) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_valid) begin
      idx <= '0;
      cur <= burst;
    end else if (res.valid && res.ready) begin
      idx <= idx + 1'b1;
    end
  end

  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> total != '0 && idx < total)
    else $error("word index outside the current burst");

  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    burst_valid |-> emit_free)
    else $error("burst loaded over one still in flight");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && last_item && !burst_valid |=> !busy)
    else $error("sequencer stayed busy after its last word");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the string handshake core with a predictor.
module testbench;

  localparam int unsigned WINDOW = 39;
  localparam int unsigned TRIES = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 45;
  localparam logic WORD_TX = 1'b0;
  localparam logic WORD_DONE = 1'b1;
  localparam logic [95:0] HANDSHAKE_TEXT = "CLIENTSERVER";

  typedef struct {
    dun_hs_pkg::opcode_t op;
    logic [7:0]          data;
  } link_cmd_t;

  typedef struct {
    logic                kind;
    logic [7:0]          tx_byte;
    dun_hs_pkg::status_t status;
    logic                ppp_seen;
    logic                last;
  } link_word_t;

  logic clk = 1'b0;
  logic rst;

  dun_hs_cfg_if cfg_ch ();
  dun_hs_cmd_if cmd_ch ();
  dun_hs_res_if res_ch ();

  dun_string_handshake_core #(
    .WINDOW_BYTES(WINDOW),
    .ATTEMPTS(TRIES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  link_cmd_t  link_items[$];
  link_word_t awaited_words[$];
  link_cmd_t  drive_item;
  link_word_t head_word;

  int sender_gap_pct = 24;
  int receiver_gap_pct = 46;
  int stall_orders = 0;
  int stall_served = 0;
  int hold_left = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int queued_items = 0;

  logic        plan_server = 1'b0;
  logic [15:0] plan_timeout = '0;

  logic        cfg_server = 1'b0;
  logic [15:0] cfg_timeout = '0;
  dun_hs_pkg::phase_t hs_phase = dun_hs_pkg::PH_IDLE;
  logic [2:0]  attempts_left = '0;
  logic [15:0] tick_count = '0;
  logic [5:0]  fill_count = '0;
  logic [3:0]  match_progress = '0;
  logic        tilde_seen = 1'b0;
  logic        nul_seen = 1'b0;

  always #10 clk = ~clk;

  function automatic logic [7:0] pattern_char(int unsigned idx);
    return HANDSHAKE_TEXT[95 - 8 * idx -: 8];
  endfunction

  function automatic void emit_word(logic kind, logic [7:0] tx, dun_hs_pkg::status_t st,
                                    logic ppp);
    link_word_t w;
    w.kind = kind;
    w.tx_byte = tx;
    w.status = st;
    w.ppp_seen = ppp;
    w.last = 1'b0;
    awaited_words.push_back(w);
  endfunction

  function automatic void emit_text(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      emit_word(WORD_TX, pattern_char(i), dun_hs_pkg::ST_OK, 1'b0);
    end
  endfunction

  function automatic void finish_handshake(dun_hs_pkg::status_t st, logic ppp);
    hs_phase = dun_hs_pkg::PH_DONE;
    emit_word(WORD_DONE, 8'h00, st, ppp);
  endfunction

  function automatic void clear_window();
    tick_count = '0;
    fill_count = '0;
    match_progress = '0;
    tilde_seen = 1'b0;
    nul_seen = 1'b0;
  endfunction

  function automatic void predict_link_word(dun_hs_pkg::opcode_t op, logic [7:0] b);
    int unsigned patlen;
    int unsigned base;
    logic [15:0] limit;
    link_word_t w;
    patlen = cfg_server ? dun_hs_pkg::SHORT_LEN : dun_hs_pkg::LONG_LEN;
    base = awaited_words.size();
    if (op == dun_hs_pkg::OP_START) begin
      clear_window();
      attempts_left = TRIES;
      hs_phase = dun_hs_pkg::PH_WAIT;
      if (!cfg_server) emit_text(dun_hs_pkg::SHORT_LEN);
    end else if (hs_phase == dun_hs_pkg::PH_WAIT && op == dun_hs_pkg::OP_BYTE) begin
      if (fill_count < WINDOW) fill_count++;
      if (!nul_seen) begin
        if (b == dun_hs_pkg::CHAR_NUL) begin
          nul_seen = 1'b1;
        end else begin
          if (b == dun_hs_pkg::CHAR_TILDE) tilde_seen = 1'b1;
          if (match_progress < patlen) begin
            if (b == pattern_char(match_progress)) match_progress++;
            else match_progress = (b == dun_hs_pkg::CHAR_C) ? 4'd1 : 4'd0;
          end
        end
      end
      if (fill_count >= patlen && match_progress >= patlen) begin
        if (cfg_server) emit_text(dun_hs_pkg::LONG_LEN);
        finish_handshake(dun_hs_pkg::ST_OK, 1'b0);
      end else if (fill_count >= patlen && tilde_seen) begin
        finish_handshake(dun_hs_pkg::ST_OK, 1'b1);
      end else if (fill_count >= WINDOW) begin
        finish_handshake(dun_hs_pkg::ST_FAIL, 1'b0);
      end
    end else if (hs_phase == dun_hs_pkg::PH_WAIT && op == dun_hs_pkg::OP_TICK) begin
      limit = cfg_server ? cfg_timeout : cfg_timeout / TRIES;
      if (limit != 0) begin
        if (tick_count != 16'hFFFF) tick_count++;
        if (tick_count >= limit) begin
          if (!cfg_server && attempts_left > 1) begin
            attempts_left--;
            clear_window();
            emit_text(dun_hs_pkg::SHORT_LEN);
          end else begin
            attempts_left = '0;
            finish_handshake(dun_hs_pkg::ST_TIMEOUT, 1'b0);
          end
        end
      end
    end else if (hs_phase == dun_hs_pkg::PH_WAIT && op == dun_hs_pkg::OP_CLOSE) begin
      finish_handshake(dun_hs_pkg::ST_FAIL, 1'b0);
    end
    if (awaited_words.size() > base) begin
      w = awaited_words.pop_back();
      w.last = 1'b1;
      awaited_words.push_back(w);
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void queue_cmd(dun_hs_pkg::opcode_t op, logic [7:0] data);
    link_cmd_t c;
    c.op = op;
    c.data = data;
    link_items.push_back(c);
    queued_items++;
  endfunction

  function automatic void queue_text(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      queue_cmd(dun_hs_pkg::OP_BYTE, pattern_char(i));
    end
  endfunction

  function automatic logic [7:0] calm_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == dun_hs_pkg::CHAR_TILDE);
    return b;
  endfunction

  function automatic void queue_session();
    int unsigned awaited_len;
    int unsigned limit;
    int unsigned pick;
    int unsigned n;
    awaited_len = plan_server ? dun_hs_pkg::SHORT_LEN : dun_hs_pkg::LONG_LEN;
    limit = plan_server ? plan_timeout : plan_timeout / TRIES;
    queue_cmd(dun_hs_pkg::OP_START, 8'($urandom));
    pick = $urandom_range(0, 11);
    case (pick)
      0, 1, 2, 3: begin
        repeat ($urandom_range(0, 6)) begin
          queue_cmd(dun_hs_pkg::OP_BYTE, calm_byte());
          if ($urandom_range(0, 3) == 0) queue_cmd(dun_hs_pkg::OP_TICK, 8'($urandom));
        end
        queue_text(awaited_len);
      end
      4, 5: begin
        n = $urandom_range(0, 3);
        repeat (n) queue_cmd(dun_hs_pkg::OP_BYTE, calm_byte());
        queue_cmd(dun_hs_pkg::OP_BYTE, dun_hs_pkg::CHAR_TILDE);
        repeat ((n + 1 < awaited_len) ? awaited_len - n - 1 : 0)
          queue_cmd(dun_hs_pkg::OP_BYTE, calm_byte());
      end
      6: begin
        n = $urandom_range(0, 4);
        repeat (n) queue_cmd(dun_hs_pkg::OP_BYTE, calm_byte());
        queue_cmd(dun_hs_pkg::OP_BYTE, dun_hs_pkg::CHAR_NUL);
        queue_cmd(dun_hs_pkg::OP_BYTE, dun_hs_pkg::CHAR_TILDE);
        queue_text(awaited_len);
        repeat (WINDOW - n - 2 - awaited_len) queue_cmd(dun_hs_pkg::OP_BYTE, 8'($urandom));
      end
      7: begin
        repeat (WINDOW) queue_cmd(dun_hs_pkg::OP_BYTE, 8'($urandom));
      end
      8, 9: begin
        if (limit == 0) n = $urandom_range(1, 4);
        else n = $urandom_range(1, (limit * TRIES + 2 < 45) ? limit * TRIES + 2 : 45);
        repeat (n) begin
          queue_cmd(dun_hs_pkg::OP_TICK, 8'($urandom));
          if ($urandom_range(0, 7) == 0) queue_cmd(dun_hs_pkg::OP_BYTE, calm_byte());
        end
      end
      10: begin
        repeat ($urandom_range(0, 5)) queue_cmd(dun_hs_pkg::OP_BYTE, calm_byte());
        queue_cmd(dun_hs_pkg::OP_CLOSE, 8'($urandom));
      end
      default: begin
        queue_text($urandom_range(1, awaited_len - 1));
        repeat ($urandom_range(0, 6))
          queue_cmd(dun_hs_pkg::opcode_t'($urandom_range(0, 3)), 8'($urandom));
      end
    endcase
  endfunction

  task automatic write_reg(dun_hs_pkg::cfg_index_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    if (idx == dun_hs_pkg::CFG_IS_SERVER) plan_server = value[0];
    else plan_timeout = value;
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (link_items.size() != 0 || cmd_ch.valid || awaited_words.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(int send_gap, int recv_gap, logic server, logic [15:0] ticks,
                           logic squeeze);
    sender_gap_pct = send_gap;
    receiver_gap_pct = recv_gap;
    write_reg(dun_hs_pkg::CFG_IS_SERVER, {15'd0, server});
    write_reg(dun_hs_pkg::CFG_TIMEOUT, ticks);
    // After an earlier phase a handshake is left open, so the new role applies to it at once.
    queue_text(server ? dun_hs_pkg::SHORT_LEN : dun_hs_pkg::LONG_LEN);
    if (squeeze) begin
      stall_orders++;
      repeat (12) queue_cmd(dun_hs_pkg::OP_START, 8'h00);
    end
    queued_items = 0;
    while (queued_items < PHASE_ITEMS) queue_session();
    queue_cmd(dun_hs_pkg::OP_START, 8'h00);
    queue_cmd(dun_hs_pkg::OP_BYTE, calm_byte());
    wait_quiet();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_ch.ready) begin
      if (link_items.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
        drive_item = link_items.pop_front();
        cmd_ch.valid <= 1'b1;
        cmd_ch.opcode <= drive_item.op;
        cmd_ch.rx_byte <= drive_item.data;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_orders != stall_served) begin
      stall_served = stall_orders;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= receiver_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == dun_hs_pkg::CFG_IS_SERVER) cfg_server = cfg_ch.data[0];
        else cfg_timeout = cfg_ch.data;
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        predict_link_word(dun_hs_pkg::opcode_t'(cmd_ch.opcode), cmd_ch.rx_byte);
      end
      if (res_ch.valid && res_ch.ready) begin
        if (awaited_words.size() == 0) begin
          $error("unexpected word: kind %0h tx_byte %0h status %0h ppp_seen %0h last %0h",
                 res_ch.kind, res_ch.tx_byte, res_ch.status, res_ch.ppp_seen, res_ch.last);
          errors++;
        end else begin
          head_word = awaited_words.pop_front();
          check_field("kind", head_word.kind, res_ch.kind);
          check_field("tx_byte", head_word.tx_byte, res_ch.tx_byte);
          check_field("status", head_word.status, res_ch.status);
          check_field("ppp_seen", head_word.ppp_seen, res_ch.ppp_seen);
          check_field("last", head_word.last, res_ch.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cfg_ch.valid && cfg_ch.ready) || (cmd_ch.valid && cmd_ch.ready) ||
        (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = dun_hs_pkg::CFG_IS_SERVER;
    cfg_ch.data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = dun_hs_pkg::OP_START;
    cmd_ch.rx_byte = '0;
    res_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_reg(dun_hs_pkg::CFG_IS_SERVER, 16'd0);
    write_reg(dun_hs_pkg::CFG_TIMEOUT, 16'd0);
    queue_cmd(dun_hs_pkg::OP_BYTE, 8'hFF);
    queue_cmd(dun_hs_pkg::OP_TICK, 8'h00);
    queue_cmd(dun_hs_pkg::OP_CLOSE, 8'h00);
    queue_cmd(dun_hs_pkg::OP_START, 8'h00);
    queue_cmd(dun_hs_pkg::OP_BYTE, dun_hs_pkg::CHAR_C);
    queue_cmd(dun_hs_pkg::OP_START, 8'hA5);
    queue_text(dun_hs_pkg::LONG_LEN);
    queue_cmd(dun_hs_pkg::OP_BYTE, dun_hs_pkg::CHAR_NUL);
    wait_quiet();
    write_reg(dun_hs_pkg::CFG_IS_SERVER, 16'd1);
    queue_cmd(dun_hs_pkg::OP_START, 8'h00);
    queue_text(dun_hs_pkg::SHORT_LEN);
    wait_quiet();

    run_phase(24, 46, 1'b0, 16'hFFFF, 1'b1);
    run_phase(24, 46, 1'b1, 16'h0000, 1'b0);
    run_phase(46, 24, 1'b0, 16'($urandom_range(4, 40)), 1'b0);
    run_phase(46, 24, 1'b1, 16'($urandom_range(1, 12)), 1'b0);
    run_phase(0, 0, 1'b0, 16'd3, 1'b0);
    run_phase(0, 0, 1'b1, 16'($urandom_range(1, 3)), 1'b0);

    repeat (20) @(posedge clk);
    if (errors == 0 && awaited_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
